// ===== rtl/tcfir_pkg.sv =====
// Shared constants and types for the two-channel FIR convolution block.
package tcfir_pkg;

   // Default build parameters.
   localparam int MAX_TAPS    = 16;
   localparam int SAMPLE_BITS = 16;

   // Fixed field widths.
   localparam int TAP_BITS       = 16;
   localparam int TAPS_PER_GROUP = 4;
   localparam int NUM_TAP_GROUPS = 4;
   localparam int OUT_BITS       = 36;
   localparam int RSP_DATA_BITS  = 2 * OUT_BITS;
   localparam int TAP_COUNT_BITS = 5;

   // Configuration port.
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAP_COUNT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAPS_A    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAPS_B    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAPS_C    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAPS_D    = 3'd4;

   // Controls from the sequencer to the tap chain.
   typedef struct packed {
      logic shift;     // move every sample one cell along
      logic clear;     // zero the whole delay line
      logic zero_in;   // feed a zero sample into the head cell
   } chain_ctl_type;

   // Controls from the sequencer to the result register.
   typedef struct packed {
      logic load;      // capture the chain sum into the result word
      logic last;      // tlast value for that word
   } rsp_ctl_type;

endpackage

// ===== rtl/tcfir_cell.sv =====
// One tap cell: holds a delayed sample, multiplies it by its tap, adds to the passing sum.
module tcfir_cell #(
   parameter int SAMPLE_BITS = tcfir_pkg::SAMPLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   shift_i,
   input  logic                                   clear_i,
   input  logic                                   tap_en_i,
   input  logic signed [tcfir_pkg::TAP_BITS-1:0]  tap_i,
   input  logic signed [SAMPLE_BITS-1:0]          samp_x_i,
   input  logic signed [SAMPLE_BITS-1:0]          samp_y_i,
   output logic signed [SAMPLE_BITS-1:0]          samp_x_o,
   output logic signed [SAMPLE_BITS-1:0]          samp_y_o,
   input  logic signed [tcfir_pkg::OUT_BITS-1:0]  psum_x_i,
   input  logic signed [tcfir_pkg::OUT_BITS-1:0]  psum_y_i,
   output logic signed [tcfir_pkg::OUT_BITS-1:0]  psum_x_o,
   output logic signed [tcfir_pkg::OUT_BITS-1:0]  psum_y_o
);

   localparam int PROD_BITS = SAMPLE_BITS + tcfir_pkg::TAP_BITS;

   logic signed [SAMPLE_BITS-1:0]         samp_x_ff, samp_x_in;
   logic signed [SAMPLE_BITS-1:0]         samp_y_ff, samp_y_in;
   logic signed [PROD_BITS-1:0]           prod_x_ff, prod_x_in;
   logic signed [PROD_BITS-1:0]           prod_y_ff, prod_y_in;
   logic signed [tcfir_pkg::OUT_BITS-1:0] psum_x_ff, psum_x_in;
   logic signed [tcfir_pkg::OUT_BITS-1:0] psum_y_ff, psum_y_in;

   // Delay-line stage: cleared at the end of a sequence, shifted per output.
   always_comb begin
      samp_x_in = samp_x_ff;
      samp_y_in = samp_y_ff;
      if (clear_i) begin
         samp_x_in = '0;
         samp_y_in = '0;
      end else if (shift_i) begin
         samp_x_in = samp_x_i;
         samp_y_in = samp_y_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         samp_x_ff <= '0;
         samp_y_ff <= '0;
      end else begin
         samp_x_ff <= samp_x_in;
         samp_y_ff <= samp_y_in;
      end
   end

   // Product of the held sample and the tap; a cell beyond the tap count adds nothing.
   assign prod_x_in = tap_en_i ? PROD_BITS'(samp_x_ff * tap_i) : '0;
   assign prod_y_in = tap_en_i ? PROD_BITS'(samp_y_ff * tap_i) : '0;

   // The running sum moves one cell along every cycle, wrapping at the output width.
   assign psum_x_in = psum_x_i + tcfir_pkg::OUT_BITS'(prod_x_ff);
   assign psum_y_in = psum_y_i + tcfir_pkg::OUT_BITS'(prod_y_ff);

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      psum_x_ff <= psum_x_in;
      psum_y_ff <= psum_y_in;
   end

   assign samp_x_o = samp_x_ff;
   assign samp_y_o = samp_y_ff;
   assign psum_x_o = psum_x_ff;
   assign psum_y_o = psum_y_ff;

endmodule

// ===== rtl/tcfir_ctrl.sv =====
// Sequencer: takes a sample, waits for the chain sum to settle, issues outputs and tails.
module tcfir_ctrl #(
   parameter int MAX_TAPS = tcfir_pkg::MAX_TAPS,
   parameter int ACT_BITS = $clog2(MAX_TAPS + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tlast,
   output logic                           req_tready,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [ACT_BITS-1:0]            active_taps,
   output tcfir_pkg::chain_ctl_type       chain_ctl,
   output tcfir_pkg::rsp_ctl_type         rsp_ctl
);

   // Cycles from a shift until the far end of the chain holds the full sum.
   localparam int SETTLE   = MAX_TAPS + 1;
   localparam int CNT_BITS = $clog2(SETTLE + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_CALC = 1'b1;

   logic                state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [ACT_BITS-1:0] tail_ff, tail_in;
   logic                last_seq_ff, last_seq_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next-state logic.
   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      tail_in           = tail_ff;
      last_seq_in       = last_seq_ff;
      chain_ctl.shift   = 1'b0;
      chain_ctl.clear   = 1'b0;
      chain_ctl.zero_in = 1'b0;
      rsp_ctl.load      = 1'b0;
      rsp_ctl.last      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               chain_ctl.shift = 1'b1;
               cnt_in          = '0;
               last_seq_in     = req_tlast;
               tail_in         = req_tlast ? active_taps - ACT_BITS'(1) : '0;
               state_in        = ST_CALC;
            end
         end
         ST_CALC: begin
            if (cnt_ff != CNT_BITS'(SETTLE)) begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end else if (out_free) begin
               rsp_ctl.load = 1'b1;
               rsp_ctl.last = last_seq_ff && (tail_ff == '0);
               if (tail_ff != '0) begin
                  // Tail output: push a zero sample and sum again.
                  chain_ctl.shift   = 1'b1;
                  chain_ctl.zero_in = 1'b1;
                  tail_in           = tail_ff - ACT_BITS'(1);
                  cnt_in            = '0;
               end else begin
                  chain_ctl.clear = last_seq_ff;
                  state_in        = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result word handshake.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ctl.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         tail_ff      <= '0;
         last_seq_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         tail_ff      <= tail_in;
         last_seq_ff  <= last_seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/two_channel_fir_convolution.sv =====
// Top level of the two-channel FIR convolution: registers, tap cell chain and sequencer.
//
//  Group  Direction  Word contents
//  req_   in         tdata: in_x, in_y (SAMPLE_BITS each); tlast: last_sample
//  rsp_   out        tdata: out_x [35:0], out_y [71:36]; tlast: last_output
//  csr_   in         wr_en, index (0 tap count, 1..4 tap groups), wdata 64 bits
//
// A sample holds the block through these steps in order: shift in, tap products, ripple
// through the cells, and the load of the result word. Each tail output of a last sample
// repeats the steps after the shift, as its zero sample shifts in on the previous load.
// Reset is synchronous; it empties the delay line, sets the tap count to one and the taps
// to zero. A stalled result word stalls the chain; a new sample is taken once the last
// result of the previous one is in the result register.
module two_channel_fir_convolution #(
   parameter int MAX_TAPS    = tcfir_pkg::MAX_TAPS,
   parameter int SAMPLE_BITS = tcfir_pkg::SAMPLE_BITS,
   parameter int REQ_DATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [REQ_DATA_BITS-1:0]               req_tdata,  // in_x, in_y, zero fill
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [tcfir_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,  // out_x, out_y
   output logic                                   rsp_tlast,
   input  logic                                   csr_wr_en,
   input  logic [tcfir_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tcfir_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int ACT_BITS = $clog2(MAX_TAPS + 1);
   localparam int OB       = tcfir_pkg::OUT_BITS;
   localparam int TB       = tcfir_pkg::TAP_BITS;
   localparam int TPG      = tcfir_pkg::TAPS_PER_GROUP;

   logic [tcfir_pkg::TAP_COUNT_BITS-1:0] tap_count_ff, tap_count_in;
   logic [tcfir_pkg::CSR_DATA_BITS-1:0]  tap_group_ff [tcfir_pkg::NUM_TAP_GROUPS];
   logic [tcfir_pkg::CSR_DATA_BITS-1:0]  tap_group_in [tcfir_pkg::NUM_TAP_GROUPS];
   logic [ACT_BITS-1:0]                  active_taps;

   tcfir_pkg::chain_ctl_type chain_ctl;
   tcfir_pkg::rsp_ctl_type   rsp_ctl;

   logic signed [SAMPLE_BITS-1:0] head_x, head_y;
   logic signed [SAMPLE_BITS-1:0] samp_x [MAX_TAPS+1];
   logic signed [SAMPLE_BITS-1:0] samp_y [MAX_TAPS+1];
   logic signed [OB-1:0]          psum_x [MAX_TAPS+1];
   logic signed [OB-1:0]          psum_y [MAX_TAPS+1];

   logic [OB-1:0] rsp_x_ff, rsp_x_in;
   logic [OB-1:0] rsp_y_ff, rsp_y_in;
   logic          rsp_last_ff, rsp_last_in;

   // Configuration registers; an unknown index is ignored.
   always_comb begin
      tap_count_in = tap_count_ff;
      for (int g = 0; g < tcfir_pkg::NUM_TAP_GROUPS; g++) begin
         tap_group_in[g] = tap_group_ff[g];
      end
      if (csr_wr_en) begin
         unique case (csr_index)
            tcfir_pkg::CSR_TAP_COUNT: tap_count_in    = csr_wdata[tcfir_pkg::TAP_COUNT_BITS-1:0];
            tcfir_pkg::CSR_TAPS_A:    tap_group_in[0] = csr_wdata;
            tcfir_pkg::CSR_TAPS_B:    tap_group_in[1] = csr_wdata;
            tcfir_pkg::CSR_TAPS_C:    tap_group_in[2] = csr_wdata;
            tcfir_pkg::CSR_TAPS_D:    tap_group_in[3] = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= tcfir_pkg::TAP_COUNT_BITS'(1);
         for (int g = 0; g < tcfir_pkg::NUM_TAP_GROUPS; g++) begin
            tap_group_ff[g] <= '0;
         end
      end else begin
         tap_count_ff <= tap_count_in;
         for (int g = 0; g < tcfir_pkg::NUM_TAP_GROUPS; g++) begin
            tap_group_ff[g] <= tap_group_in[g];
         end
      end
   end

   // Taps in use: zero counts as one, anything above the chain length as the full chain.
   always_comb begin
      if (tap_count_ff == '0) begin
         active_taps = ACT_BITS'(1);
      end else if (32'(tap_count_ff) > MAX_TAPS) begin
         active_taps = ACT_BITS'(MAX_TAPS);
      end else begin
         active_taps = ACT_BITS'(tap_count_ff);
      end
   end

   // Sample entering the head of the chain: the new word, or zero for tail outputs.
   assign head_x    = chain_ctl.zero_in ? '0 : req_tdata[SAMPLE_BITS-1:0];
   assign head_y    = chain_ctl.zero_in ? '0 : req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign samp_x[0] = head_x;
   assign samp_y[0] = head_y;
   assign psum_x[0] = '0;
   assign psum_y[0] = '0;

   // Chain of tap cells.
   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      logic tap_en;
      assign tap_en = ACT_BITS'(k) < active_taps;

      tcfir_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_i  (chain_ctl.shift),
         .clear_i  (chain_ctl.clear),
         .tap_en_i (tap_en),
         .tap_i    (tap_group_ff[k / TPG][TB*(k % TPG) +: TB]),
         .samp_x_i (samp_x[k]),
         .samp_y_i (samp_y[k]),
         .samp_x_o (samp_x[k+1]),
         .samp_y_o (samp_y[k+1]),
         .psum_x_i (psum_x[k]),
         .psum_y_i (psum_y[k]),
         .psum_x_o (psum_x[k+1]),
         .psum_y_o (psum_y[k+1])
      );
   end

   tcfir_ctrl #(
      .MAX_TAPS (MAX_TAPS),
      .ACT_BITS (ACT_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tlast   (req_tlast),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .active_taps (active_taps),
      .chain_ctl   (chain_ctl),
      .rsp_ctl     (rsp_ctl)
   );

   // Result word register.
   always_comb begin
      rsp_x_in    = rsp_x_ff;
      rsp_y_in    = rsp_y_ff;
      rsp_last_in = rsp_last_ff;
      if (rsp_ctl.load) begin
         rsp_x_in    = psum_x[MAX_TAPS];
         rsp_y_in    = psum_y[MAX_TAPS];
         rsp_last_in = rsp_ctl.last;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tdata = {rsp_y_ff, rsp_x_ff};
   assign rsp_tlast = rsp_last_ff;

endmodule

// ===== rtl/tcfir_checker.sv =====
// Port-level checks for the two-channel FIR convolution, bound to the top level.
module tcfir_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [tcfir_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                                rsp_tlast
);

   // After reset the block is empty and ready for a word.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty and ready after reset");

   // One sample at a time: a taken word makes the block busy.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready stayed high after a word was taken");

   // A new result cannot appear in the cycle after a sample is taken.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result word appeared too early");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

endmodule

bind two_channel_fir_convolution tcfir_checker u_tcfir_checker (.*);

// ===== bench/two_channel_fir_convolution_tb.sv =====
// Self-checking bench for the two-channel FIR convolution: stimulus, prediction and checking.
module two_channel_fir_convolution_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS    = tcfir_pkg::SAMPLE_BITS;
   localparam int MAX_TAPS       = tcfir_pkg::MAX_TAPS;
   localparam int OUT_BITS       = tcfir_pkg::OUT_BITS;
   localparam int RSP_DATA_BITS  = tcfir_pkg::RSP_DATA_BITS;
   localparam int CSR_INDEX_BITS = tcfir_pkg::CSR_INDEX_BITS;
   localparam int CSR_DATA_BITS  = tcfir_pkg::CSR_DATA_BITS;
   localparam int TAP_COUNT_BITS = tcfir_pkg::TAP_COUNT_BITS;
   localparam int NUM_TAP_GROUPS = tcfir_pkg::NUM_TAP_GROUPS;
   localparam int TAP_BITS       = tcfir_pkg::TAP_BITS;
   localparam int TAPS_PER_GROUP = tcfir_pkg::TAPS_PER_GROUP;

   localparam int REQ_BITS     = ((2 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int HIST_DEPTH   = MAX_TAPS - 1;
   localparam int SETTLE_TIME  = MAX_TAPS + 8;
   localparam int IDLE_PERCENT = 20;
   localparam int TARGET_WORDS = 310;

   localparam logic [SAMPLE_BITS-1:0] Q15_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] Q15_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};

   // One expected result word.
   typedef struct {
      logic [OUT_BITS-1:0] out_x;
      logic [OUT_BITS-1:0] out_y;
      logic                last_output;
   } conv_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_BITS-1:0]       req_tdata = '0;        // in_x, in_y
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;             // out_x, out_y
   logic                      rsp_tlast;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Predicted state of the filter.
   logic [TAP_COUNT_BITS-1:0]     model_tap_count;
   logic [CSR_DATA_BITS-1:0]      model_tap_groups [NUM_TAP_GROUPS];
   logic signed [SAMPLE_BITS-1:0] history_x [HIST_DEPTH];
   logic signed [SAMPLE_BITS-1:0] history_y [HIST_DEPTH];
   logic signed [SAMPLE_BITS-1:0] window_x [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] window_y [MAX_TAPS];
   conv_word_type                 pending_outputs [$];
   conv_word_type                 expected_word;

   int  fail_count    = 0;
   int  words_sent    = 0;
   int  words_checked = 0;
   int  sequences     = 0;
   int  csr_writes    = 0;
   int  hold_cycles   = 0;
   bit  steady_flow   = 1'b0;

   two_channel_fir_convolution uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Tap k taken from its packed group.
   function automatic logic signed [TAP_BITS-1:0] tap_value(input int k);
      return model_tap_groups[k / TAPS_PER_GROUP][TAP_BITS * (k % TAPS_PER_GROUP) +: TAP_BITS];
   endfunction

   // A count of zero acts as one tap, and anything above the chain length as the full chain.
   function automatic int taps_in_use();
      if (model_tap_count == 0) return 1;
      if (model_tap_count > MAX_TAPS) return MAX_TAPS;
      return int'(model_tap_count);
   endfunction

   // Full-precision dot product of the taps with the current window, wrapped to the output width.
   function automatic conv_word_type window_sum(input int taps, input logic last_flag);
      longint                     acc_x;
      longint                     acc_y;
      logic signed [TAP_BITS-1:0] coeff;
      conv_word_type              word;
      acc_x = 0;
      acc_y = 0;
      for (int k = 0; k < taps; k++) begin
         coeff = tap_value(k);
         acc_x += longint'(coeff) * longint'(window_x[k]);
         acc_y += longint'(coeff) * longint'(window_y[k]);
      end
      word.out_x       = acc_x[OUT_BITS-1:0];
      word.out_y       = acc_y[OUT_BITS-1:0];
      word.last_output = last_flag;
      return word;
   endfunction

   // Works out every result word that one accepted sample causes, and advances the history.
   task automatic convolve_input(input logic [SAMPLE_BITS-1:0] in_x,
                                 input logic [SAMPLE_BITS-1:0] in_y,
                                 input logic last_sample);
      int taps;
      taps = taps_in_use();
      window_x[0] = in_x;
      window_y[0] = in_y;
      for (int i = 1; i < MAX_TAPS; i++) begin
         window_x[i] = history_x[i - 1];
         window_y[i] = history_y[i - 1];
      end
      pending_outputs.push_back(window_sum(taps, last_sample && taps == 1));
      if (last_sample) begin
         // The tail of the convolution: zeros shift in until the last sample reaches the last tap in use.
         for (int j = 1; j < taps; j++) begin
            for (int i = MAX_TAPS - 1; i > 0; i--) begin
               window_x[i] = window_x[i - 1];
               window_y[i] = window_y[i - 1];
            end
            window_x[0] = '0;
            window_y[0] = '0;
            pending_outputs.push_back(window_sum(taps, j == taps - 1));
         end
         for (int i = 0; i < HIST_DEPTH; i++) begin
            history_x[i] = '0;
            history_y[i] = '0;
         end
      end else begin
         for (int i = HIST_DEPTH - 1; i > 0; i--) begin
            history_x[i] = history_x[i - 1];
            history_y[i] = history_y[i - 1];
         end
         history_x[0] = in_x;
         history_y[0] = in_y;
      end
   endtask

   // Register write on the configuration port, mirrored into the predicted state.
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (index)
         tcfir_pkg::CSR_TAP_COUNT: model_tap_count     = value[TAP_COUNT_BITS-1:0];
         tcfir_pkg::CSR_TAPS_A:    model_tap_groups[0] = value;
         tcfir_pkg::CSR_TAPS_B:    model_tap_groups[1] = value;
         tcfir_pkg::CSR_TAPS_C:    model_tap_groups[2] = value;
         tcfir_pkg::CSR_TAPS_D:    model_tap_groups[3] = value;
         default: ;
      endcase
      csr_writes++;
   endtask

   // Offers one sample word, now and then with a random gap before it outside steady flow, and waits until it is taken.
   task automatic send_word(input logic [SAMPLE_BITS-1:0] in_x,
                            input logic [SAMPLE_BITS-1:0] in_y,
                            input logic last_sample);
      @(negedge clock);
      if (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = REQ_BITS'({in_y, in_x});
      req_tlast  = last_sample;
      do @(posedge clock); while (!req_tready);
      convolve_input(in_x, in_y, last_sample);
      words_sent++;
   endtask

   // Stops offering and waits until every predicted word has come back and the chain is quiet.
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      req_tlast  = 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_TIME) @(posedge clock);
   endtask

   // Q1.15 value, weighted towards the extremes.
   function automatic logic [SAMPLE_BITS-1:0] pick_q15();
      case ($urandom_range(9))
         0: return Q15_MIN;
         1: return Q15_MAX;
         2: return '0;
         3: return '1;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_tap_group();
      logic [CSR_DATA_BITS-1:0] group;
      for (int k = 0; k < TAPS_PER_GROUP; k++)
         group[k * TAP_BITS +: TAP_BITS] = pick_q15();
      return group;
   endfunction

   function automatic logic [TAP_COUNT_BITS-1:0] pick_tap_count();
      case ($urandom_range(7))
         0: return '0;
         1: return TAP_COUNT_BITS'(1);
         2: return TAP_COUNT_BITS'(MAX_TAPS);
         3: return '1;
         default: return TAP_COUNT_BITS'($urandom_range(MAX_TAPS, 1));
      endcase
   endfunction

   // A whole sequence of random samples, marked last on its final word.
   task automatic send_sequence(input int length);
      for (int i = 0; i < length; i++)
         send_word(pick_q15(), pick_q15(), i == length - 1);
      sequences++;
   endtask

   // Fresh random taps in every group, and a tap count with junk above its field.
   task automatic load_random_setting(input logic [TAP_COUNT_BITS-1:0] count);
      logic [CSR_DATA_BITS-1:0] junk;
      junk = {$urandom, $urandom};
      write_csr(tcfir_pkg::CSR_TAP_COUNT, {junk[CSR_DATA_BITS-1:TAP_COUNT_BITS], count});
      write_csr(tcfir_pkg::CSR_TAPS_A, pick_tap_group());
      write_csr(tcfir_pkg::CSR_TAPS_B, pick_tap_group());
      write_csr(tcfir_pkg::CSR_TAPS_C, pick_tap_group());
      write_csr(tcfir_pkg::CSR_TAPS_D, pick_tap_group());
   endtask

   // After reset: one tap of value zero, so every output is zero.
   task automatic test_power_on_state();
      send_word(Q15_MAX, Q15_MIN, 1'b0);
      send_word(Q15_MIN, Q15_MAX, 1'b1);
      wait_for_drain();
   endtask

   // A single tap at both ends of its range against extreme samples, then zero and minus one.
   task automatic test_single_tap_extremes();
      write_csr(tcfir_pkg::CSR_TAP_COUNT, CSR_DATA_BITS'(1));
      write_csr(tcfir_pkg::CSR_TAPS_A, {{(CSR_DATA_BITS - TAP_BITS){1'b0}}, Q15_MIN});
      send_word(Q15_MIN, Q15_MAX, 1'b0);
      send_word(Q15_MAX, Q15_MIN, 1'b1);
      wait_for_drain();
      write_csr(tcfir_pkg::CSR_TAPS_A, {{(CSR_DATA_BITS - TAP_BITS){1'b0}}, Q15_MAX});
      send_word('0, '1, 1'b1);
      wait_for_drain();
   endtask

   // Full chain with all taps at the extremes, giving the largest sums and the longest tail.
   task automatic test_full_chain_extremes();
      write_csr(tcfir_pkg::CSR_TAP_COUNT, CSR_DATA_BITS'(MAX_TAPS));
      write_csr(tcfir_pkg::CSR_TAPS_A, {TAPS_PER_GROUP{Q15_MIN}});
      write_csr(tcfir_pkg::CSR_TAPS_B, {TAPS_PER_GROUP{Q15_MIN}});
      write_csr(tcfir_pkg::CSR_TAPS_C, {TAPS_PER_GROUP{Q15_MIN}});
      write_csr(tcfir_pkg::CSR_TAPS_D, {TAPS_PER_GROUP{Q15_MIN}});
      for (int i = 0; i < 4; i++)
         send_word(Q15_MIN, Q15_MAX, i == 3);
      wait_for_drain();
      write_csr(tcfir_pkg::CSR_TAPS_A, {TAPS_PER_GROUP{Q15_MAX}});
      write_csr(tcfir_pkg::CSR_TAPS_D, {TAPS_PER_GROUP{Q15_MAX}});
      send_word(Q15_MAX, Q15_MIN, 1'b0);
      send_word(Q15_MIN, Q15_MIN, 1'b1);
      wait_for_drain();
   endtask

   // A tap count of zero acts as one; counts above the chain length act as the full chain.
   task automatic test_tap_count_limits();
      write_csr(tcfir_pkg::CSR_TAP_COUNT, '0);
      send_word(pick_q15(), pick_q15(), 1'b0);
      send_word(pick_q15(), pick_q15(), 1'b1);
      wait_for_drain();
      write_csr(tcfir_pkg::CSR_TAP_COUNT, '1);
      send_word(pick_q15(), pick_q15(), 1'b0);
      send_word(pick_q15(), pick_q15(), 1'b1);
      wait_for_drain();
   endtask

   // Writes to indexes past the last register must change nothing.
   task automatic test_spare_indexes();
      for (int idx = tcfir_pkg::CSR_TAPS_D + 1; idx < 2 ** CSR_INDEX_BITS; idx++)
         write_csr(CSR_INDEX_BITS'(idx), '1);
      send_word(Q15_MAX, Q15_MAX, 1'b0);
      send_word(Q15_MIN, Q15_MAX, 1'b1);
      wait_for_drain();
   endtask

   // The history keeps its samples when the tap count grows part way through a sequence.
   task automatic test_count_change_mid_sequence();
      load_random_setting(TAP_COUNT_BITS'(3));
      for (int i = 0; i < 4; i++)
         send_word(pick_q15(), pick_q15(), 1'b0);
      wait_for_drain();
      write_csr(tcfir_pkg::CSR_TAP_COUNT, CSR_DATA_BITS'(MAX_TAPS - 2));
      send_word(pick_q15(), pick_q15(), 1'b0);
      send_word(pick_q15(), pick_q15(), 1'b1);
      sequences++;
      wait_for_drain();
   endtask

   // The result side holds off for a long while as samples keep coming, so the input stalls.
   task automatic test_result_hold_off();
      load_random_setting(TAP_COUNT_BITS'(5));
      hold_cycles = 400;
      send_sequence(4);
      send_sequence(6);
      wait (hold_cycles == 0);
      wait_for_drain();
   endtask

   // Phases of random settings, each carrying well-formed sequences of random samples.
   task automatic test_random_sequences();
      int phase;
      phase = 0;
      while (words_sent < TARGET_WORDS) begin
         steady_flow = (phase == 2);
         load_random_setting(pick_tap_count());
         repeat ($urandom_range(6, 3)) begin
            // Mostly ordinary lengths, now and then a lone last word.
            if ($urandom_range(4) == 0)
               send_sequence(1);
            else
               send_sequence($urandom_range(10, 2));
         end
         wait_for_drain();
         phase++;
      end
      steady_flow = 1'b0;
   endtask

   // Result side: random back-pressure, and a long hold-off when one is asked for.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready = steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Each accepted result word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outputs.size() == 0) begin
            $error("unexpected result word: out_x %0d out_y %0d last %0b",
                   $signed(rsp_tdata[OUT_BITS-1:0]),
                   $signed(rsp_tdata[2*OUT_BITS-1:OUT_BITS]), rsp_tlast);
            fail_count++;
         end else begin
            expected_word = pending_outputs.pop_front();
            if (rsp_tdata[OUT_BITS-1:0] !== expected_word.out_x) begin
               $error("out_x: expected %0d, got %0d", $signed(expected_word.out_x),
                      $signed(rsp_tdata[OUT_BITS-1:0]));
               fail_count++;
            end
            if (rsp_tdata[2*OUT_BITS-1:OUT_BITS] !== expected_word.out_y) begin
               $error("out_y: expected %0d, got %0d", $signed(expected_word.out_y),
                      $signed(rsp_tdata[2*OUT_BITS-1:OUT_BITS]));
               fail_count++;
            end
            if (rsp_tlast !== expected_word.last_output) begin
               $error("last_output: expected %0b, got %0b", expected_word.last_output,
                      rsp_tlast);
               fail_count++;
            end
            words_checked++;
         end
      end
   end

   // Main sequence of tests.
   initial begin
      model_tap_count = TAP_COUNT_BITS'(1);
      for (int g = 0; g < NUM_TAP_GROUPS; g++)
         model_tap_groups[g] = '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
         history_x[i] = '0;
         history_y[i] = '0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_power_on_state();
      test_single_tap_extremes();
      test_full_chain_extremes();
      test_tap_count_limits();
      test_spare_indexes();
      test_count_change_mid_sequence();
      test_result_hold_off();
      test_random_sequences();
      wait_for_drain();

      $display("Run covered %0d sample words in %0d sequences and %0d checked result words.",
               words_sent, sequences, words_checked);
      $display("Settings came from %0d register writes, tap counts from zero to the top.",
               csr_writes);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Guard against a hang.
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
